// ----- design/bafm_pkg.sv -----
// shared types and constants for the block allocator with fit and merge
package bafm_pkg;

    localparam int FREE_ENTRIES = 16;
    localparam int USED_ENTRIES = 32;
    localparam int FIDX_W = $clog2(FREE_ENTRIES);
    localparam int UIDX_W = $clog2(USED_ENTRIES);
    localparam int FCNT_W = $clog2(FREE_ENTRIES + 1);
    localparam int UCNT_W = $clog2(USED_ENTRIES + 1);
    localparam int ADDR_W = 24;
    localparam int LIMIT_W = 25;

    localparam logic [ADDR_W-1:0] MB = 24'd1048576;
    localparam logic [ADDR_W-1:0] ADDR_MAX = 24'hFFFFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd4194304;
    localparam logic [FCNT_W-1:0] FREE_INIT_COUNT = 5'd5;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_DEALLOC = 2'd1;
    localparam logic [1:0] CMD_TERM = 2'd2;
    // spare code; the block answers it with an OK result and changes no table
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic CFG_FIT_MODE = 1'b0;
    localparam logic CFG_MERGE_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  process_id;
        logic [7:0]  block_id;
        logic [23:0] request_size;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] start_address;
        logic [23:0] found_size;
        logic [5:0]  freed_count;
    } out_t;

    typedef enum logic [10:0] {
        S_IDLE        = 11'b00000000001,
        S_ALLOC_SCAN  = 11'b00000000010,
        S_ALLOC_APPLY = 11'b00000000100,
        S_DEALLOC     = 11'b00000001000,
        S_TERM        = 11'b00000010000,
        S_REL_DROP    = 11'b00000100000,
        S_REL_POS     = 11'b00001000000,
        S_REL_INS     = 11'b00010000000,
        S_MRG_LOAD    = 11'b00100000000,
        S_MRG_CMP     = 11'b01000000000,
        S_DONE        = 11'b10000000000
    } state_t;

    // reset contents of the free table
    function automatic logic [ADDR_W-1:0] init_start(input int idx);
        logic [ADDR_W-1:0] v;
        v = '0;
        unique case (idx)
            0: v = 24'd3 * MB;
            1: v = 24'd4 * MB;
            2: v = 24'd6 * MB;
            3: v = 24'd8 * MB;
            4: v = 24'd12 * MB;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] init_size(input int idx);
        logic [ADDR_W-1:0] v;
        v = '0;
        unique case (idx)
            0: v = MB;
            1: v = 24'd2 * MB;
            2: v = 24'd2 * MB;
            3: v = 24'd4 * MB;
            4: v = 24'd4 * MB;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/block_allocator_fit_merge.sv -----
// top level of the block allocator: free and in-use tables under one sequencer
// One command is taken at a time; s_ready is high only while the sequencer is idle.
// An allocate walks the free table one entry a cycle.
// A deallocate walks the in-use table newest first, one entry a cycle, then
// releases the block: a drop step, an address search of one free entry a cycle,
// an insert step, and a merge scan that compares one adjacent free pair a cycle
// and restarts from the head after every merge. A terminate repeats the release
// for each matching block. The result is held in an output register, so the
// next command is taken while a result waits on m_ready.
module block_allocator_fit_merge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bafm_pkg::in_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output bafm_pkg::out_t               m_data,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bafm_pkg::LIMIT_W-1:0] cfg_data
);

    localparam int FE = bafm_pkg::FREE_ENTRIES;
    localparam int UE = bafm_pkg::USED_ENTRIES;
    localparam int FIW = bafm_pkg::FIDX_W;
    localparam int UIW = bafm_pkg::UIDX_W;
    localparam int FCW = bafm_pkg::FCNT_W;
    localparam int UCW = bafm_pkg::UCNT_W;
    localparam int AW = bafm_pkg::ADDR_W;
    localparam int LW = bafm_pkg::LIMIT_W;

    bafm_pkg::state_t state_reg, state_next;

    // configuration
    logic          fit_mode_reg, fit_mode_next;
    logic [LW-1:0] merge_limit_reg, merge_limit_next;

    // free table
    logic [AW-1:0]  fstart_reg [FE], fstart_next [FE];
    logic [AW-1:0]  fsize_reg  [FE], fsize_next  [FE];
    logic [FCW-1:0] fcount_reg, fcount_next;

    // in-use table
    logic [AW-1:0]  ustart_reg [UE], ustart_next [UE];
    logic [AW-1:0]  usize_reg  [UE], usize_next  [UE];
    logic [7:0]     uproc_reg  [UE], uproc_next  [UE];
    logic [7:0]     ublk_reg   [UE], ublk_next   [UE];
    logic [UCW-1:0] ucount_reg, ucount_next;

    // command and working registers
    bafm_pkg::in_t  cmd_reg, cmd_next;
    logic [FCW-1:0] fi_reg, fi_next;
    logic [FIW-1:0] pick_reg, pick_next;
    logic [AW-1:0]  slack_reg, slack_next;
    logic           got_reg, got_next;
    logic [UCW-1:0] ui_reg, ui_next;
    logic [UIW-1:0] k_reg, k_next;
    logic [AW-1:0]  rs_reg, rs_next;
    logic [AW-1:0]  rz_reg, rz_next;
    logic [AW-1:0]  hstart_reg, hstart_next;
    logic [AW-1:0]  hsize_reg, hsize_next;
    logic [1:0]     status_reg, status_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [AW-1:0]  fsz_reg, fsz_next;
    logic [5:0]     freed_reg, freed_next;

    // output register
    logic           m_valid_reg, m_valid_next;
    bafm_pkg::out_t m_data_reg, m_data_next;

    // shared read ports and arithmetic
    logic [FIW-1:0] frd_idx;
    logic [AW-1:0]  frd_start, frd_size;
    logic [UIW-1:0] urd_idx;
    logic [UCW-1:0] ui_dec;
    logic [LW-1:0]  bound;
    logic [LW-1:0]  pair_sum;
    logic [LW-1:0]  hold_end;
    logic [AW-1:0]  diff;

    assign s_ready = (state_reg == bafm_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign ui_dec  = ui_reg - UCW'(1);
    assign bound   = (merge_limit_reg < {1'b0, bafm_pkg::ADDR_MAX}) ?
                     merge_limit_reg : {1'b0, bafm_pkg::ADDR_MAX};
    assign diff    = frd_size - cmd_reg.request_size;
    assign pair_sum = {1'b0, hsize_reg} + {1'b0, frd_size};
    assign hold_end = {1'b0, hstart_reg} + {1'b0, hsize_reg};

    // free table read address
    always_comb begin
        unique case (state_reg)
            bafm_pkg::S_ALLOC_APPLY: frd_idx = pick_reg;
            bafm_pkg::S_MRG_CMP:     frd_idx = FIW'(fi_reg + FCW'(1));
            default:                 frd_idx = fi_reg[FIW-1:0];
        endcase
    end
    assign frd_start = fstart_reg[frd_idx];
    assign frd_size  = fsize_reg[frd_idx];

    // in-use table read address
    always_comb begin
        unique case (state_reg)
            bafm_pkg::S_REL_DROP: urd_idx = k_reg;
            default:              urd_idx = ui_dec[UIW-1:0];
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        fit_mode_next = fit_mode_reg;
        merge_limit_next = merge_limit_reg;
        fstart_next = fstart_reg;
        fsize_next = fsize_reg;
        fcount_next = fcount_reg;
        ustart_next = ustart_reg;
        usize_next = usize_reg;
        uproc_next = uproc_reg;
        ublk_next = ublk_reg;
        ucount_next = ucount_reg;
        cmd_next = cmd_reg;
        fi_next = fi_reg;
        pick_next = pick_reg;
        slack_next = slack_reg;
        got_next = got_reg;
        ui_next = ui_reg;
        k_next = k_reg;
        rs_next = rs_reg;
        rz_next = rz_reg;
        hstart_next = hstart_reg;
        hsize_next = hsize_reg;
        status_next = status_reg;
        addr_next = addr_reg;
        fsz_next = fsz_reg;
        freed_next = freed_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;

        // configuration writes
        if (cfg_we) begin
            unique case (cfg_index)
                bafm_pkg::CFG_FIT_MODE:    fit_mode_next = cfg_data[0];
                bafm_pkg::CFG_MERGE_LIMIT: merge_limit_next = cfg_data;
                default:                   fit_mode_next = fit_mode_reg;
            endcase
        end

        // output transfer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            bafm_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_data;
                    status_next = bafm_pkg::ST_OK;
                    addr_next = '0;
                    fsz_next = '0;
                    freed_next = '0;
                    fi_next = '0;
                    got_next = 1'b0;
                    slack_next = '0;
                    pick_next = '0;
                    ui_next = ucount_reg;
                    unique case (s_data.cmd)
                        bafm_pkg::CMD_ALLOC: begin
                            if (ucount_reg >= UCW'(UE)) begin
                                status_next = bafm_pkg::ST_FULL;
                                state_next = bafm_pkg::S_DONE;
                            end else begin
                                state_next = bafm_pkg::S_ALLOC_SCAN;
                            end
                        end
                        bafm_pkg::CMD_DEALLOC: state_next = bafm_pkg::S_DEALLOC;
                        bafm_pkg::CMD_TERM:    state_next = bafm_pkg::S_TERM;
                        default:               state_next = bafm_pkg::S_DONE;
                    endcase
                end
            end

            // one free entry per cycle, first or best fit
            bafm_pkg::S_ALLOC_SCAN: begin
                if (fi_reg >= fcount_reg) begin
                    state_next = bafm_pkg::S_ALLOC_APPLY;
                end else begin
                    fi_next = fi_reg + FCW'(1);
                    if (frd_size >= cmd_reg.request_size) begin
                        if (!fit_mode_reg) begin
                            pick_next = fi_reg[FIW-1:0];
                            got_next = 1'b1;
                            state_next = bafm_pkg::S_ALLOC_APPLY;
                        end else if (!got_reg || diff < slack_reg) begin
                            pick_next = fi_reg[FIW-1:0];
                            slack_next = diff;
                            got_next = 1'b1;
                            if (diff == '0) begin
                                state_next = bafm_pkg::S_ALLOC_APPLY;
                            end
                        end
                    end
                end
            end

            // carve from the chosen block and record it in use, or report no fit
            bafm_pkg::S_ALLOC_APPLY: begin
                state_next = bafm_pkg::S_DONE;
                if (!got_reg) begin
                    status_next = bafm_pkg::ST_NO_FIT;
                end else begin
                    addr_next = frd_start;
                    fsz_next = frd_size;
                    ustart_next[ucount_reg[UIW-1:0]] = frd_start;
                    usize_next[ucount_reg[UIW-1:0]] = cmd_reg.request_size;
                    uproc_next[ucount_reg[UIW-1:0]] = cmd_reg.process_id;
                    ublk_next[ucount_reg[UIW-1:0]] = cmd_reg.block_id;
                    ucount_next = ucount_reg + UCW'(1);
                    if (diff == '0) begin
                        for (int j = 0; j < FE - 1; j++) begin
                            if (j >= int'(pick_reg)) begin
                                fstart_next[j] = fstart_reg[j+1];
                                fsize_next[j] = fsize_reg[j+1];
                            end
                        end
                        fcount_next = fcount_reg - FCW'(1);
                    end else begin
                        fstart_next[pick_reg] = frd_start + cmd_reg.request_size;
                        fsize_next[pick_reg] = diff;
                    end
                end
            end

            // newest matching block, one entry per cycle
            bafm_pkg::S_DEALLOC: begin
                if (ui_reg == '0) begin
                    status_next = bafm_pkg::ST_NOT_FOUND;
                    state_next = bafm_pkg::S_DONE;
                end else if (uproc_reg[urd_idx] == cmd_reg.process_id &&
                             ublk_reg[urd_idx] == cmd_reg.block_id) begin
                    k_next = urd_idx;
                    state_next = bafm_pkg::S_REL_DROP;
                end else begin
                    ui_next = ui_dec;
                end
            end

            // every block of the process, newest first
            bafm_pkg::S_TERM: begin
                if (ui_reg == '0) begin
                    status_next = (freed_reg == '0) ? bafm_pkg::ST_NOT_FOUND : bafm_pkg::ST_OK;
                    state_next = bafm_pkg::S_DONE;
                end else if (uproc_reg[urd_idx] == cmd_reg.process_id) begin
                    k_next = urd_idx;
                    state_next = bafm_pkg::S_REL_DROP;
                end else begin
                    ui_next = ui_dec;
                end
            end

            // take the block out of the in-use table, or report full when the free table is full
            bafm_pkg::S_REL_DROP: begin
                if (fcount_reg >= FCW'(FE)) begin
                    status_next = bafm_pkg::ST_FULL;
                    state_next = bafm_pkg::S_DONE;
                end else begin
                    rs_next = ustart_reg[urd_idx];
                    rz_next = usize_reg[urd_idx];
                    for (int j = 0; j < UE - 1; j++) begin
                        if (j >= int'(k_reg)) begin
                            ustart_next[j] = ustart_reg[j+1];
                            usize_next[j] = usize_reg[j+1];
                            uproc_next[j] = uproc_reg[j+1];
                            ublk_next[j] = ublk_reg[j+1];
                        end
                    end
                    ucount_next = ucount_reg - UCW'(1);
                    fi_next = '0;
                    state_next = bafm_pkg::S_REL_POS;
                end
            end

            // address-ordered insert position
            bafm_pkg::S_REL_POS: begin
                if (fi_reg < fcount_reg && frd_start <= rs_reg) begin
                    fi_next = fi_reg + FCW'(1);
                end else begin
                    state_next = bafm_pkg::S_REL_INS;
                end
            end

            bafm_pkg::S_REL_INS: begin
                for (int j = 1; j < FE; j++) begin
                    if (j > int'(fi_reg)) begin
                        fstart_next[j] = fstart_reg[j-1];
                        fsize_next[j] = fsize_reg[j-1];
                    end
                end
                fstart_next[fi_reg[FIW-1:0]] = rs_reg;
                fsize_next[fi_reg[FIW-1:0]] = rz_reg;
                fcount_next = fcount_reg + FCW'(1);
                fi_next = '0;
                state_next = bafm_pkg::S_MRG_LOAD;
            end

            // merge scan from the head
            bafm_pkg::S_MRG_LOAD: begin
                hstart_next = frd_start;
                hsize_next = frd_size;
                state_next = bafm_pkg::S_MRG_CMP;
            end

            bafm_pkg::S_MRG_CMP: begin
                if (fi_reg + FCW'(1) >= fcount_reg) begin
                    freed_next = freed_reg + 6'd1;
                    if (cmd_reg.cmd == bafm_pkg::CMD_DEALLOC) begin
                        state_next = bafm_pkg::S_DONE;
                    end else begin
                        ui_next = UCW'(k_reg);
                        state_next = bafm_pkg::S_TERM;
                    end
                end else if (hold_end == {1'b0, frd_start} && pair_sum <= bound) begin
                    fsize_next[fi_reg[FIW-1:0]] = pair_sum[AW-1:0];
                    for (int j = 1; j < FE - 1; j++) begin
                        if (j > int'(fi_reg)) begin
                            fstart_next[j] = fstart_reg[j+1];
                            fsize_next[j] = fsize_reg[j+1];
                        end
                    end
                    fcount_next = fcount_reg - FCW'(1);
                    fi_next = '0;
                    state_next = bafm_pkg::S_MRG_LOAD;
                end else begin
                    hstart_next = frd_start;
                    hsize_next = frd_size;
                    fi_next = fi_reg + FCW'(1);
                end
            end

            // hand the result to the output register
            bafm_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.status = status_reg;
                    m_data_next.start_address = addr_reg;
                    m_data_next.found_size = fsz_reg;
                    m_data_next.freed_count = freed_reg;
                    state_next = bafm_pkg::S_IDLE;
                end
            end

            default: state_next = bafm_pkg::S_IDLE;
        endcase
    end

    // control and free table registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bafm_pkg::S_IDLE;
            fit_mode_reg <= 1'b0;
            merge_limit_reg <= bafm_pkg::LIMIT_RESET;
            fcount_reg <= bafm_pkg::FREE_INIT_COUNT;
            ucount_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j < FE; j++) begin
                fstart_reg[j] <= bafm_pkg::init_start(j);
                fsize_reg[j] <= bafm_pkg::init_size(j);
            end
        end else begin
            state_reg <= state_next;
            fit_mode_reg <= fit_mode_next;
            merge_limit_reg <= merge_limit_next;
            fcount_reg <= fcount_next;
            ucount_reg <= ucount_next;
            m_valid_reg <= m_valid_next;
            fstart_reg <= fstart_next;
            fsize_reg <= fsize_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ustart_reg <= ustart_next;
        usize_reg <= usize_next;
        uproc_reg <= uproc_next;
        ublk_reg <= ublk_next;
        cmd_reg <= cmd_next;
        fi_reg <= fi_next;
        pick_reg <= pick_next;
        slack_reg <= slack_next;
        got_reg <= got_next;
        ui_reg <= ui_next;
        k_reg <= k_next;
        rs_reg <= rs_next;
        rz_reg <= rz_next;
        hstart_reg <= hstart_next;
        hsize_reg <= hsize_next;
        status_reg <= status_next;
        addr_reg <= addr_next;
        fsz_reg <= fsz_next;
        freed_reg <= freed_next;
        m_data_reg <= m_data_next;
    end

    // table fill levels stay in range
    a_fcount: assert property (@(posedge aclk) disable iff (!aresetn)
        fcount_reg <= FCW'(FE))
        else $error("free table count out of range");

    a_ucount: assert property (@(posedge aclk) disable iff (!aresetn)
        ucount_reg <= UCW'(UE))
        else $error("in-use table count out of range");

    // allocate results never report freed blocks
    a_alloc_freed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bafm_pkg::S_ALLOC_APPLY) |=> (freed_reg == '0))
        else $error("allocate reported freed blocks");

    // a release never runs with the in-use table empty
    a_rel_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bafm_pkg::S_REL_DROP) |-> (ucount_reg != '0))
        else $error("release with empty in-use table");

endmodule

// ----- dv/tb_top.sv -----
// testbench for the block allocator: directed and random command streams against a predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 200000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    bafm_pkg::in_t s_data;
    logic m_valid;
    logic m_ready;
    bafm_pkg::out_t m_data;
    logic cfg_we;
    logic cfg_index;
    logic [bafm_pkg::LIMIT_W-1:0] cfg_data;

    block_allocator_fit_merge i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // predictor state
    logic                         pm_best_fit;
    logic [bafm_pkg::LIMIT_W-1:0] pm_merge_limit;
    int unsigned fr_start [bafm_pkg::FREE_ENTRIES];
    int unsigned fr_size [bafm_pkg::FREE_ENTRIES];
    int unsigned fr_count;
    int unsigned us_start [bafm_pkg::USED_ENTRIES];
    int unsigned us_size [bafm_pkg::USED_ENTRIES];
    int unsigned us_pid [bafm_pkg::USED_ENTRIES];
    int unsigned us_bid [bafm_pkg::USED_ENTRIES];
    int unsigned us_count;

    bafm_pkg::out_t expected_results[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int ready_hold;
    bit timed_out = 1'b0;
    bit no_stall;

    task automatic alloc_reset_tables();
        fr_count = 5;
        for (int i = 0; i < 5; i++) begin
            fr_start[i] = bafm_pkg::init_start(i);
            fr_size[i] = bafm_pkg::init_size(i);
        end
        us_count = 0;
    endtask

    function automatic void free_remove(int unsigned k);
        for (int unsigned i = k; i + 1 < fr_count; i++) begin
            fr_start[i] = fr_start[i+1];
            fr_size[i] = fr_size[i+1];
        end
        fr_count--;
    endfunction

    function automatic void used_remove(int unsigned k);
        for (int unsigned i = k; i + 1 < us_count; i++) begin
            us_start[i] = us_start[i+1];
            us_size[i] = us_size[i+1];
            us_pid[i] = us_pid[i+1];
            us_bid[i] = us_bid[i+1];
        end
        us_count--;
    endfunction

    // coalesce adjacent free blocks, restarting from the head after each merge
    function automatic void coalesce_free();
        int unsigned bound;
        int unsigned i;
        int unsigned sum;
        bound = (pm_merge_limit < 25'hFFFFFF) ? pm_merge_limit : 32'hFFFFFF;
        i = 0;
        while (i + 1 < fr_count) begin
            sum = fr_size[i] + fr_size[i+1];
            if (fr_start[i] + fr_size[i] == fr_start[i+1] && sum <= bound) begin
                fr_start[i+1] = fr_start[i];
                fr_size[i+1] = sum;
                free_remove(i);
                i = 0;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic bit release_block(int unsigned k);
        int unsigned s;
        int unsigned z;
        int unsigned pos;
        if (fr_count >= bafm_pkg::FREE_ENTRIES) return 1'b0;
        s = us_start[k];
        z = us_size[k];
        used_remove(k);
        pos = 0;
        while (pos < fr_count && fr_start[pos] <= s) pos++;
        for (int unsigned i = fr_count; i > pos; i--) begin
            fr_start[i] = fr_start[i-1];
            fr_size[i] = fr_size[i-1];
        end
        fr_start[pos] = s;
        fr_size[pos] = z;
        fr_count++;
        coalesce_free();
        return 1'b1;
    endfunction

    function automatic bafm_pkg::out_t predict_allocator(bafm_pkg::in_t req);
        bafm_pkg::out_t r;
        bit got;
        bit full;
        int unsigned pick;
        int unsigned slack;
        int unsigned rs;
        int unsigned freed;
        r = '0;
        rs = req.request_size;
        got = 0;
        full = 0;
        pick = 0;
        slack = 0;
        freed = 0;
        if (req.cmd == bafm_pkg::CMD_ALLOC) begin
            if (us_count >= bafm_pkg::USED_ENTRIES) begin
                r.status = bafm_pkg::ST_FULL;
            end else begin
                for (int unsigned i = 0; i < fr_count; i++) begin
                    if (fr_size[i] < rs) continue;
                    if (!pm_best_fit) begin
                        pick = i;
                        got = 1;
                        break;
                    end
                    if (!got || fr_size[i] - rs < slack) begin
                        pick = i;
                        slack = fr_size[i] - rs;
                        got = 1;
                        if (slack == 0) break;
                    end
                end
                if (!got) begin
                    r.status = bafm_pkg::ST_NO_FIT;
                end else begin
                    r.start_address = fr_start[pick];
                    r.found_size = fr_size[pick];
                    us_start[us_count] = fr_start[pick];
                    us_size[us_count] = rs;
                    us_pid[us_count] = req.process_id;
                    us_bid[us_count] = req.block_id;
                    us_count++;
                    fr_size[pick] = fr_size[pick] - rs;
                    if (fr_size[pick] == 0) free_remove(pick);
                    else fr_start[pick] = (fr_start[pick] + rs) & 32'hFFFFFF;
                end
            end
        end else if (req.cmd == bafm_pkg::CMD_DEALLOC) begin
            for (int unsigned i = us_count; i > 0; i--) begin
                if (us_pid[i-1] == req.process_id && us_bid[i-1] == req.block_id) begin
                    pick = i - 1;
                    got = 1;
                    break;
                end
            end
            if (!got) r.status = bafm_pkg::ST_NOT_FOUND;
            else if (!release_block(pick)) r.status = bafm_pkg::ST_FULL;
            else r.freed_count = 6'd1;
        end else if (req.cmd == bafm_pkg::CMD_TERM) begin
            for (int unsigned i = us_count; i > 0; i--) begin
                if (us_pid[i-1] != req.process_id) continue;
                if (!release_block(i - 1)) begin
                    full = 1;
                    break;
                end
                freed++;
            end
            if (full) r.status = bafm_pkg::ST_FULL;
            else if (freed == 0) r.status = bafm_pkg::ST_NOT_FOUND;
            r.freed_count = freed[5:0];
        end
        return r;
    endfunction

    // one command transfer, with an optional random gap first
    task automatic send_command(input logic [1:0] c, input int pid, input int bid,
                                input int unsigned rs);
        bafm_pkg::in_t item;
        bafm_pkg::out_t exp_item;
        item.cmd = c;
        item.process_id = pid[7:0];
        item.block_id = bid[7:0];
        item.request_size = rs[23:0];
        if (!no_stall && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp_item = predict_allocator(item);
        expected_results = {expected_results, exp_item};
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0 && !timed_out) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_config(input logic idx, input int unsigned v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[bafm_pkg::LIMIT_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == bafm_pkg::CFG_FIT_MODE) pm_best_fit = v[0];
        else pm_merge_limit = v[bafm_pkg::LIMIT_W-1:0];
    endtask

    // result stall control, holding m_ready low in random bursts
    always @(negedge aclk) begin
        if (!aresetn || no_stall) begin
            ready_hold <= 0;
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        bafm_pkg::out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_data);
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d addr=%h size=%h freed=%0d",
                                 exp_r.status, exp_r.start_address, exp_r.found_size,
                                 exp_r.freed_count,
                                 " got st=%0d addr=%h size=%h freed=%0d",
                                 m_data.status, m_data.start_address,
                                 m_data.found_size, m_data.freed_count);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        send_command(bafm_pkg::CMD_DEALLOC, 1, 1, 0);
        send_command(bafm_pkg::CMD_TERM, 1, 0, 0);
        send_command(bafm_pkg::CMD_ALLOC, 1, 1, 0);
        send_command(bafm_pkg::CMD_ALLOC, 1, 2, bafm_pkg::MB);
        send_command(bafm_pkg::CMD_ALLOC, 2, 1, 2 * bafm_pkg::MB);
        send_command(bafm_pkg::CMD_ALLOC, 255, 255, 24'hFFFFFF);
        send_command(bafm_pkg::CMD_ALLOC, 3, 0, 3 * bafm_pkg::MB);
        send_command(bafm_pkg::CMD_ALLOC, 3, 1, 1);
        send_command(bafm_pkg::CMD_NOP, 255, 255, 24'hFFFFFF);
        send_command(bafm_pkg::CMD_DEALLOC, 1, 2, 0);
        send_command(bafm_pkg::CMD_DEALLOC, 1, 2, 0);
        send_command(bafm_pkg::CMD_TERM, 2, 0, 0);
        send_command(bafm_pkg::CMD_TERM, 3, 0, 0);
        send_command(bafm_pkg::CMD_TERM, 1, 0, 0);
        write_config(bafm_pkg::CFG_FIT_MODE, 1);
        send_command(bafm_pkg::CMD_ALLOC, 0, 0, 2 * bafm_pkg::MB);
        send_command(bafm_pkg::CMD_ALLOC, 0, 1, 3 * bafm_pkg::MB);
        send_command(bafm_pkg::CMD_ALLOC, 0, 2, 0);
        send_command(bafm_pkg::CMD_TERM, 0, 0, 0);
    endtask

    // fill the in-use table past capacity, then release with a tiny merge limit
    task automatic test_table_full();
        write_config(bafm_pkg::CFG_MERGE_LIMIT, 0);
        for (int i = 0; i < bafm_pkg::USED_ENTRIES + 2; i++)
            send_command(bafm_pkg::CMD_ALLOC, i % 3, i, 4096);
        for (int i = 0; i < 20; i++) send_command(bafm_pkg::CMD_DEALLOC, i % 3, i, 0);
        send_command(bafm_pkg::CMD_TERM, 0, 0, 0);
        send_command(bafm_pkg::CMD_TERM, 1, 0, 0);
        send_command(bafm_pkg::CMD_TERM, 2, 0, 0);
        write_config(bafm_pkg::CFG_MERGE_LIMIT, 25'h1000000);
        send_command(bafm_pkg::CMD_TERM, 0, 0, 0);
    endtask

    task automatic random_phase(input int n);
        int unsigned rs;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: rs = $urandom_range(0, 24'hFFFFFF);
                1: rs = $urandom_range(0, 65535);
                default: rs = $urandom_range(1, 2 * bafm_pkg::MB);
            endcase
            if (k < 55) send_command(bafm_pkg::CMD_ALLOC, $urandom_range(0, 7),
                                     $urandom_range(0, 7), rs);
            else if (k < 85) send_command(bafm_pkg::CMD_DEALLOC, $urandom_range(0, 7),
                                          $urandom_range(0, 7), $urandom);
            else if (k < 97) send_command(bafm_pkg::CMD_TERM, $urandom_range(0, 7),
                                          $urandom, $urandom);
            else send_command(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_random();
        write_config(bafm_pkg::CFG_FIT_MODE, 0);
        write_config(bafm_pkg::CFG_MERGE_LIMIT, bafm_pkg::LIMIT_RESET);
        random_phase(500);
        write_config(bafm_pkg::CFG_FIT_MODE, 1);
        write_config(bafm_pkg::CFG_MERGE_LIMIT, 25'h1000000);
        random_phase(500);
        write_config(bafm_pkg::CFG_MERGE_LIMIT, $urandom_range(0, 25'h1FFFFFF));
        random_phase(400);
        write_config(bafm_pkg::CFG_FIT_MODE, 0);
        write_config(bafm_pkg::CFG_MERGE_LIMIT, 25'h1FFFFFF);
        random_phase(300);
        no_stall = 1'b1;
        random_phase(300);
    endtask

    initial begin
        no_stall = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = bafm_pkg::CFG_FIT_MODE;
        cfg_data = '0;
        pm_best_fit = 1'b0;
        pm_merge_limit = bafm_pkg::LIMIT_RESET;
        alloc_reset_tables();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_table_full();
        test_random();
        wait_drained();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/bafm_pkg.sv
design/block_allocator_fit_merge.sv
dv/tb_top.sv
